// File: src/slsc_pkg.sv
// Shared constants, register codes and table-building functions for the spectrogram column block.
package slsc_pkg;

    localparam int FFT_SIZE_DEF = 128;
    localparam int HOP_SIZE_DEF = 64;

    localparam int SAMPLE_W    = 16;
    localparam int CHAN_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int BIN_W       = 6;
    localparam int COL_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PART_W      = 24;
    localparam int GAIN18_W    = 21;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_SEL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_TOT = 2'd3;

    localparam logic [15:0]         GAIN_RESET     = 16'd256;
    localparam logic [GAIN18_W-1:0] GAIN18_RESET   = GAIN18_W'(256 * 18);
    localparam logic [COL_W-1:0]    COLUMNS_RESET  = 12'd64;
    localparam logic [COL_W-1:0]    MIN_COLUMNS    = 12'd64;
    localparam logic [3:0]          CHAN_TOT_RESET = 4'd1;

    localparam int SQRT_STEPS = 32;
    localparam int LOG_STEPS  = 20;

    // 255 * log10(2) in Q16
    localparam logic [22:0] LOG_SCALE_Q16 = 23'd5030717;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint SDIV [7] = '{210, 156, 110, 72, 42, 20, 6};
    localparam longint CDIV [8] = '{240, 182, 132, 90, 56, 30, 12, 2};

    // round half up from Q30 to Q15 and saturate
    function automatic longint to_q15(longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32768)
            r = -64'sd32768;
        return r;
    endfunction

    // cosine in [31:16], sine in [15:0], both Q1.15, for a phase in turns/2^32
    function automatic logic [31:0] cos_sin_q15(logic [31:0] phase);
        longint r;
        longint x;
        longint x2;
        longint t;
        longint s;
        longint c;
        longint co;
        longint si;
        logic [1:0] quad;
        quad = phase[31:30];
        r = longint'({34'd0, phase[29:0]});
        x = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t = ONE_Q30;
        for (int i = 0; i < 7; i++)
            t = ONE_Q30 - ((x2 * t) >>> 30) / SDIV[i];
        s = (x * t) >>> 30;
        t = ONE_Q30;
        for (int i = 0; i < 8; i++)
            t = ONE_Q30 - ((x2 * t) >>> 30) / CDIV[i];
        c = t;
        case (quad)
            2'd0:
            begin
                co = to_q15(c);
                si = to_q15(s);
            end
            2'd1:
            begin
                co = to_q15(-s);
                si = to_q15(c);
            end
            2'd2:
            begin
                co = to_q15(-c);
                si = to_q15(-s);
            end
            default:
            begin
                co = to_q15(s);
                si = to_q15(-c);
            end
        endcase
        return {co[15:0], si[15:0]};
    endfunction

    // Hann coefficient in Q1.15 for a phase in turns/2^32
    function automatic logic [15:0] hann_q15(logic [31:0] phase);
        logic [31:0] cs;
        longint c;
        longint h;
        cs = cos_sin_q15(phase);
        c = longint'($signed(cs[31:16]));
        h = (64'sd32768 - c + 64'sd1) >>> 1;
        if (h > 64'sd32767)
            h = 64'sd32767;
        return h[15:0];
    endfunction

endpackage

// File: src/stft_log_spectrogram_column_top.sv
// Top level of the log-magnitude spectrogram column generator.
// Usage: interleaved audio samples enter on the sample channel (sample_valid/sample_ready);
// only the selected channel is kept in a ring of FFT_SIZE samples. When the ring fills, a
// frame runs: Hann window, radix-2 FFT in place in the transform memory, then FFT_SIZE/2
// bin beats leave on the bin channel (bin_valid/bin_ready), bin 0 first, last_bin on the
// final one. Registers are written on the cfg channel (always ready); the user must write
// them only while idle, the block itself does not enforce it. A sample that does not fill
// the ring is taken whenever the block is idle; a filling sample starts a frame. The
// butterfly pass is set by the single write port of the transform memory (two writes per
// butterfly); each bin is set by the bit-serial square root (32 steps) and the log loop
// (20 squarings), fewer when the bin saturates. sample_ready is low during a frame.
// Reset: the ring empties, the column cursor is zero and registers take their defaults;
// the memories are not cleared, only written entries are ever read.
// Stall: a bin beat waits in the output register while the next bin is computed; the
// frame holds only when a second bin is ready and the first has not been taken.
module stft_log_spectrogram_column_top #(
    parameter int FFT_SIZE = slsc_pkg::FFT_SIZE_DEF,
    parameter int HOP_SIZE = slsc_pkg::HOP_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [slsc_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [slsc_pkg::CHAN_W-1:0]         sample_channel,
    output logic                                bin_valid,
    input  logic                                bin_ready,
    output logic [slsc_pkg::BYTE_W-1:0]         magnitude_byte,
    output logic [slsc_pkg::BIN_W-1:0]          bin_number,
    output logic [slsc_pkg::COL_W-1:0]          column_number,
    output logic                                last_bin,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW         = $clog2(FFT_SIZE);
    localparam int HALF       = FFT_SIZE / 2;
    localparam int BCW        = AW - 1;
    localparam int SW         = $clog2(AW);
    localparam int GAIN_SHIFT = AW - 2;
    localparam int PW         = slsc_pkg::PART_W;
    localparam int TWW        = 2 * slsc_pkg::PART_W;

    localparam logic [AW-1:0] HOP_MOD   = AW'(HOP_SIZE % FFT_SIZE);
    localparam logic [AW:0]   FILL_FULL = (AW + 1)'(FFT_SIZE);
    localparam logic [AW:0]   FILL_KEEP = (HOP_SIZE >= FFT_SIZE) ? '0
                                          : (AW + 1)'(FFT_SIZE - HOP_SIZE);
    localparam logic [SW-1:0] LAST_STAGE = SW'(AW - 1);
    localparam logic [4:0]    SQRT_LAST  = 5'(slsc_pkg::SQRT_STEPS - 1);
    localparam logic [4:0]    LOG_LAST   = 5'(slsc_pkg::LOG_STEPS - 1);
    localparam logic [52:0]   Y_ONE      = 53'h0_0001_0000_0000;
    localparam logic [52:0]   Y_SAT      = 53'h0_000a_0000_0000;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_LOAD = 11'b00000000010,
        S_BFLY = 11'b00000000100,
        S_RDM  = 11'b00000001000,
        S_SQR  = 11'b00000010000,
        S_PWR  = 11'b00000100000,
        S_SQRT = 11'b00001000000,
        S_GAIN = 11'b00010000000,
        S_LOGP = 11'b00100000000,
        S_LOG  = 11'b01000000000,
        S_BYTE = 11'b10000000000
    } state_t;

    function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] a);
        logic [AW-1:0] r;
        for (int n = 0; n < AW; n++)
            r[n] = a[AW-1-n];
        return r;
    endfunction

    // Window and twiddle tables, fixed at elaboration
    logic        [15:0] hann_rom [FFT_SIZE];
    logic signed [15:0] twr_rom  [HALF];
    logic signed [15:0] twi_rom  [HALF];

    for (genvar g = 0; g < FFT_SIZE; g++)
    begin : g_hann
        localparam logic [63:0] HPH  = (64'(g) << 32) / (64'(FFT_SIZE) - 64'd1);
        localparam logic [15:0] HVAL = slsc_pkg::hann_q15(HPH[31:0]);
        assign hann_rom[g] = HVAL;
    end

    for (genvar g = 0; g < HALF; g++)
    begin : g_twid
        localparam logic [31:0] TPH = 32'(64'(g) << (32 - AW));
        localparam logic [31:0] TCS = slsc_pkg::cos_sin_q15(TPH);
        localparam logic [15:0] TIM = 16'(-$signed(TCS[15:0]));
        assign twr_rom[g] = $signed(TCS[31:16]);
        assign twi_rom[g] = $signed(TIM);
    end

    // Configuration registers
    logic [slsc_pkg::GAIN18_W-1:0] gain18_reg;
    logic [slsc_pkg::COL_W-1:0]    columns_reg;
    logic [2:0]                    chan_sel_reg;
    logic [3:0]                    chan_tot_reg;

    // Control registers
    state_t         state_reg, state_next;
    logic [AW:0]    fill_reg, fill_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [slsc_pkg::COL_W-1:0] cursor_reg, cursor_next;
    logic [AW:0]    cnt_reg, cnt_next;
    logic [SW-1:0]  stage_reg, stage_next;
    logic [BCW-1:0] bfly_reg, bfly_next;
    logic [1:0]     ph_reg, ph_next;
    logic [BCW-1:0] bin_reg, bin_next;
    logic [4:0]     it_reg, it_next;
    logic           ld_v1_reg, ld_v2_reg;
    logic [AW-1:0]  ld_i1_reg, ld_i2_reg;
    logic           out_valid_reg;

    // Datapath registers
    logic [15:0]        sw_rd_reg;
    logic [TWW-1:0]     tw_rda_reg, tw_rdb_reg;
    logic signed [32:0] ld_prod_reg;
    logic signed [39:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [47:0]        sq_re_reg, sq_im_reg;
    logic [62:0]        sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [51:0]        gm_reg;
    logic               sat_reg;
    logic [1:0]         k_reg;
    logic [31:0]        z_reg;
    logic [19:0]        frac_reg;
    logic [slsc_pkg::BYTE_W-1:0] byte_reg;
    logic [slsc_pkg::BIN_W-1:0]  bin_out_reg;
    logic [slsc_pkg::COL_W-1:0]  col_out_reg;
    logic                        last_out_reg;

    // Memories
    logic [15:0]    sw_mem [FFT_SIZE];
    logic [TWW-1:0] tw_mem [FFT_SIZE];

    logic           sw_we;
    logic [AW-1:0]  sw_wa, sw_ra;
    logic           ld_issue;
    logic           tw_re, tw_we;
    logic [AW-1:0]  tw_wa, tw_ra, tw_rb;
    logic [TWW-1:0] tw_wd;

    logic sample_accept;
    logic out_load;
    logic slot_free;

    // channel selection and image width in use
    logic [3:0]                 stride;
    logic [3:0]                 sel_max;
    logic [2:0]                 sel_eff;
    logic [slsc_pkg::COL_W-1:0] width_eff;
    logic [slsc_pkg::COL_W:0]   cursor_inc;

    assign stride    = (chan_tot_reg == 4'd0) ? 4'd1 : chan_tot_reg;
    assign sel_max   = stride - 4'd1;
    assign sel_eff   = ({1'b0, chan_sel_reg} > sel_max) ? sel_max[2:0] : chan_sel_reg;
    assign width_eff = (columns_reg < slsc_pkg::MIN_COLUMNS) ? slsc_pkg::MIN_COLUMNS
                                                               : columns_reg;
    assign cursor_inc = {1'b0, cursor_reg} + 13'd1;

    // Window load path
    logic signed [33:0]   ld_sum;
    logic signed [PW-1:0] ld_re;

    assign ld_issue = (state_reg == S_LOAD) && (cnt_reg != FILL_FULL);
    assign sw_ra    = base_reg + cnt_reg[AW-1:0];
    assign sw_wa    = base_reg + fill_reg[AW-1:0];
    assign ld_sum   = 34'(ld_prod_reg) + 34'sd16384;
    assign ld_re    = PW'(ld_sum >>> 15);

    // Butterfly addressing
    logic [BCW-1:0] bf_mask, bf_k, bf_grp, twd_idx;
    logic [AW-1:0]  addr_u, addr_b;

    assign bf_mask = ~({BCW{1'b1}} << stage_reg);
    assign bf_k    = bfly_reg & bf_mask;
    assign bf_grp  = bfly_reg & ~bf_mask;
    assign addr_u  = {bf_grp, 1'b0} | {1'b0, bf_k};
    assign addr_b  = addr_u | (AW'(1) << stage_reg);
    assign twd_idx = bf_k << (BCW - int'(stage_reg));

    // Butterfly arithmetic
    logic signed [PW-1:0] ua_re, ua_im, rb_re, rb_im;
    logic signed [15:0]   w_re, w_im;
    logic signed [40:0]   vr_sum, vi_sum;
    logic signed [PW-1:0] v_re, v_im;
    logic [TWW-1:0]       bf_top, bf_bot;

    assign ua_re  = $signed(tw_rda_reg[TWW-1:PW]);
    assign ua_im  = $signed(tw_rda_reg[PW-1:0]);
    assign rb_re  = $signed(tw_rdb_reg[TWW-1:PW]);
    assign rb_im  = $signed(tw_rdb_reg[PW-1:0]);
    assign w_re   = twr_rom[twd_idx];
    assign w_im   = twi_rom[twd_idx];
    assign vr_sum = 41'(p_rr_reg) - 41'(p_ii_reg) + 41'sd16384;
    assign vi_sum = 41'(p_ri_reg) + 41'(p_ir_reg) + 41'sd16384;
    assign v_re   = PW'(vr_sum >>> 15);
    assign v_im   = PW'(vi_sum >>> 15);
    assign bf_top = {PW'(ua_re + v_re), PW'(ua_im + v_im)};
    assign bf_bot = {PW'(ua_re - v_re), PW'(ua_im - v_im)};

    // Magnitude, square root and log
    logic [48:0] pw_sum;
    logic [63:0] sq_trial;
    logic        sq_take;
    logic [52:0] y_val;
    logic [1:0]  y_k;
    logic [31:0] y_z;
    logic [61:0] zz;
    logic [31:0] zs;
    logic [44:0] bp;
    logic [8:0]  bv;
    logic [slsc_pkg::BYTE_W-1:0] byte_val;

    assign pw_sum   = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_take  = {1'b0, sq_v_reg} >= sq_trial;
    assign y_val    = 53'(gm_reg >> GAIN_SHIFT) + Y_ONE;

    always_comb
    begin
        if (y_val[35:33] == 3'd0)
            y_k = 2'd0;
        else if (y_val[35:34] == 2'd0)
            y_k = 2'd1;
        else if (!y_val[35])
            y_k = 2'd2;
        else
            y_k = 2'd3;
    end

    always_comb
    begin
        case (y_k)
            2'd0:    y_z = y_val[33:2];
            2'd1:    y_z = y_val[34:3];
            2'd2:    y_z = y_val[35:4];
            default: y_z = y_val[36:5];
        endcase
    end

    assign zz       = z_reg[30:0] * z_reg[30:0];
    assign zs       = zz[61:30];
    assign bp       = {k_reg, frac_reg} * slsc_pkg::LOG_SCALE_Q16;
    assign bv       = bp[44:36];
    assign byte_val = (sat_reg || bv[8]) ? 8'hff : bv[7:0];

    assign sample_ready  = (state_reg == S_IDLE);
    assign sample_accept = sample_valid && sample_ready;
    assign cfg_ready     = 1'b1;
    assign slot_free     = !out_valid_reg || bin_ready;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        base_next   = base_reg;
        cursor_next = cursor_reg;
        cnt_next    = cnt_reg;
        stage_next  = stage_reg;
        bfly_next   = bfly_reg;
        ph_next     = ph_reg;
        bin_next    = bin_reg;
        it_next     = it_reg;
        sw_we       = 1'b0;
        tw_re       = 1'b0;
        tw_we       = 1'b0;
        tw_wa       = addr_u;
        tw_wd       = bf_top;
        tw_ra       = addr_u;
        tw_rb       = addr_b;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_accept && (sample_channel == sel_eff))
                begin
                    sw_we     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == FILL_FULL - 1'b1)
                    begin
                        state_next = S_LOAD;
                        cnt_next   = '0;
                    end
                end
            end
            S_LOAD:
            begin
                if (cnt_reg != FILL_FULL)
                    cnt_next = cnt_reg + 1'b1;
                if (ld_v2_reg)
                begin
                    // bit-reversed placement replaces the swap pass
                    tw_we = 1'b1;
                    tw_wa = bit_rev(ld_i2_reg);
                    tw_wd = {ld_re, {PW{1'b0}}};
                end
                if ((cnt_reg == FILL_FULL) && !ld_v1_reg && !ld_v2_reg)
                begin
                    state_next = S_BFLY;
                    stage_next = '0;
                    bfly_next  = '0;
                    ph_next    = 2'd0;
                end
            end
            S_BFLY:
            begin
                ph_next = ph_reg + 2'd1;
                case (ph_reg)
                    2'd0:
                        tw_re = 1'b1;
                    2'd2:
                    begin
                        tw_we = 1'b1;
                        tw_wa = addr_u;
                        tw_wd = bf_top;
                    end
                    2'd3:
                    begin
                        tw_we = 1'b1;
                        tw_wa = addr_b;
                        tw_wd = bf_bot;
                        if (bfly_reg == {BCW{1'b1}})
                        begin
                            bfly_next = '0;
                            if (stage_reg == LAST_STAGE)
                            begin
                                state_next = S_RDM;
                                bin_next   = '0;
                            end
                            else
                                stage_next = stage_reg + 1'b1;
                        end
                        else
                            bfly_next = bfly_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDM:
            begin
                tw_re      = 1'b1;
                tw_ra      = AW'(bin_reg);
                state_next = S_SQR;
            end
            S_SQR:
                state_next = S_PWR;
            S_PWR:
            begin
                it_next    = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == SQRT_LAST)
                    state_next = S_GAIN;
            end
            S_GAIN:
                state_next = S_LOGP;
            S_LOGP:
            begin
                it_next    = '0;
                state_next = (y_val >= Y_SAT) ? S_BYTE : S_LOG;
            end
            S_LOG:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == LOG_LAST)
                    state_next = S_BYTE;
            end
            S_BYTE:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (bin_reg == {BCW{1'b1}})
                    begin
                        // close the frame: advance cursor, drop the hop
                        state_next  = S_IDLE;
                        cursor_next = (cursor_inc >= {1'b0, width_eff}) ? '0
                                                                        : cursor_inc[11:0];
                        base_next   = base_reg + HOP_MOD;
                        fill_next   = FILL_KEEP;
                    end
                    else
                    begin
                        bin_next   = bin_reg + 1'b1;
                        state_next = S_RDM;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cfg_valid && (cfg_index == slsc_pkg::CFG_COLUMNS))
            cursor_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            base_reg      <= '0;
            cursor_reg    <= '0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            bfly_reg      <= '0;
            ph_reg        <= 2'd0;
            bin_reg       <= '0;
            it_reg        <= '0;
            ld_v1_reg     <= 1'b0;
            ld_v2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            gain18_reg    <= slsc_pkg::GAIN18_RESET;
            columns_reg   <= slsc_pkg::COLUMNS_RESET;
            chan_sel_reg  <= '0;
            chan_tot_reg  <= slsc_pkg::CHAN_TOT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            base_reg   <= base_next;
            cursor_reg <= cursor_next;
            cnt_reg    <= cnt_next;
            stage_reg  <= stage_next;
            bfly_reg   <= bfly_next;
            ph_reg     <= ph_next;
            bin_reg    <= bin_next;
            it_reg     <= it_next;
            ld_v1_reg  <= ld_issue;
            ld_v2_reg  <= ld_v1_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (bin_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    slsc_pkg::CFG_GAIN:
                        // hold 18*gain, the only form the log stage needs
                        gain18_reg <= slsc_pkg::GAIN18_W'({cfg_data, 4'b0000})
                                    + slsc_pkg::GAIN18_W'({cfg_data, 1'b0});
                    slsc_pkg::CFG_COLUMNS:
                        columns_reg <= cfg_data[slsc_pkg::COL_W-1:0];
                    slsc_pkg::CFG_CHAN_SEL:
                        chan_sel_reg <= cfg_data[2:0];
                    slsc_pkg::CFG_CHAN_TOT:
                        chan_tot_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Sample ring
    always_ff @(posedge clk)
    begin
        if (sw_we)
            sw_mem[sw_wa] <= sample_value;
        if (ld_issue)
            sw_rd_reg <= sw_mem[sw_ra];
    end

    // Transform memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (tw_we)
            tw_mem[tw_wa] <= tw_wd;
        if (tw_re)
        begin
            tw_rda_reg <= tw_mem[tw_ra];
            tw_rdb_reg <= tw_mem[tw_rb];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ld_i1_reg <= cnt_reg[AW-1:0];
        ld_i2_reg <= ld_i1_reg;
        if (ld_v1_reg)
            ld_prod_reg <= $signed(sw_rd_reg) * $signed({1'b0, hann_rom[ld_i1_reg]});
        if ((state_reg == S_BFLY) && (ph_reg == 2'd1))
        begin
            p_rr_reg <= rb_re * w_re;
            p_ii_reg <= rb_im * w_im;
            p_ri_reg <= rb_re * w_im;
            p_ir_reg <= rb_im * w_re;
        end
        if (state_reg == S_SQR)
        begin
            sq_re_reg <= 48'(ua_re * ua_re);
            sq_im_reg <= 48'(ua_im * ua_im);
        end
        if (state_reg == S_PWR)
        begin
            sq_v_reg   <= {pw_sum, 14'd0};
            sq_res_reg <= '0;
            sq_bit_reg <= 63'(1) << 62;
        end
        if (state_reg == S_SQRT)
        begin
            if (sq_take)
            begin
                sq_v_reg   <= sq_v_reg - sq_trial[62:0];
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (state_reg == S_GAIN)
            gm_reg <= gain18_reg * sq_res_reg[30:0];
        if (state_reg == S_LOGP)
        begin
            sat_reg  <= (y_val >= Y_SAT);
            k_reg    <= y_k;
            z_reg    <= y_z;
            frac_reg <= '0;
        end
        if (state_reg == S_LOG)
        begin
            frac_reg <= {frac_reg[18:0], zs[31]};
            z_reg    <= zs[31] ? {1'b0, zs[31:1]} : zs;
        end
        if (out_load)
        begin
            byte_reg     <= byte_val;
            bin_out_reg  <= slsc_pkg::BIN_W'(bin_reg);
            col_out_reg  <= cursor_reg;
            last_out_reg <= (bin_reg == {BCW{1'b1}});
        end
    end

    assign bin_valid      = out_valid_reg;
    assign magnitude_byte = byte_reg;
    assign bin_number     = bin_out_reg;
    assign column_number  = col_out_reg;
    assign last_bin       = last_out_reg;

    // Checks
    a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |-> (fill_reg < FILL_FULL))
        else $error("sample taken with a full ring");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !tw_we)
        else $error("transform memory written while idle");

    a_bfly_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BFLY) |-> (addr_u != addr_b))
        else $error("butterfly legs address the same entry");

    a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAIN) |-> (sq_res_reg[62:31] == '0))
        else $error("magnitude exceeds 31 bits");

endmodule
